FILE: hdl/rc6_block_cipher_top_defines.svh
// ----------------------------------------------------------------------------
// RC6 block cipher assertion macros
// Concurrent check wrappers shared by the cipher RTL; ASSERT_OFF removes them.
// ----------------------------------------------------------------------------
`ifndef RC6_BLOCK_CIPHER_TOP_DEFINES_SVH
`define RC6_BLOCK_CIPHER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// Check on every clock edge outside reset.
`define RC6_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// Check on every clock edge, reset included.
`define RC6_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);
`else
`define RC6_ASSERT(lbl, prop, msg)
`define RC6_ASSERT_RST(lbl, prop, msg)
`endif

`endif

FILE: hdl/rc6_pkg.sv
// ----------------------------------------------------------------------------
// RC6 package
// Payload types, codes, constants and word functions of the RC6-32 cipher.
// ----------------------------------------------------------------------------
`default_nettype none

package rc6_pkg;

    localparam int RC6_ROUNDS        = 20;
    localparam int RC6_MAX_KEY_WORDS = 8;
    localparam int RC6_WORD_W        = 32;
    localparam int RC6_ROT_W         = 5;

    localparam logic [RC6_WORD_W-1:0] RC6_P32 = 32'hB7E1_5163;
    localparam logic [RC6_WORD_W-1:0] RC6_Q32 = 32'h9E37_79B9;
    localparam logic [RC6_ROT_W-1:0]  RC6_LGW = 5'd5;
    localparam logic [RC6_ROT_W-1:0]  RC6_KEY_ROT = 5'd3;

    // request mode codes
    localparam logic [1:0] MODE_KEY = 2'd0;
    localparam logic [1:0] MODE_ENC = 2'd1;
    localparam logic [1:0] MODE_DEC = 2'd2;

    // result status codes
    localparam logic [1:0] ST_BLOCK    = 2'd0;
    localparam logic [1:0] ST_STORED   = 2'd1;
    localparam logic [1:0] ST_EXPANDED = 2'd2;
    localparam logic [1:0] ST_DROPPED  = 2'd3;

    typedef struct packed {
        logic [1:0]            mode;
        logic [RC6_WORD_W-1:0] key_word;
        logic                  key_final;
        logic [RC6_WORD_W-1:0] word_a;
        logic [RC6_WORD_W-1:0] word_b;
        logic [RC6_WORD_W-1:0] word_c;
        logic [RC6_WORD_W-1:0] word_d;
    } t_in_item;

    typedef struct packed {
        logic [RC6_WORD_W-1:0] out_a;
        logic [RC6_WORD_W-1:0] out_b;
        logic [RC6_WORD_W-1:0] out_c;
        logic [RC6_WORD_W-1:0] out_d;
        logic [1:0]            status;
    } t_out_item;

    typedef struct packed {
        logic [RC6_WORD_W-1:0] a;
        logic [RC6_WORD_W-1:0] b;
        logic [RC6_WORD_W-1:0] c;
        logic [RC6_WORD_W-1:0] d;
    } t_block;

    // round unit operation, one flag per step
    typedef struct packed {
        logic load;
        logic zero;
        logic pre;
        logic mul;
        logic mix;
        logic post;
        logic dec;
    } t_ru_ctrl;

    function automatic logic [RC6_WORD_W-1:0] f_rotl(input logic [RC6_WORD_W-1:0] x,
                                                      input logic [RC6_ROT_W-1:0]  n);
        logic [2*RC6_WORD_W-1:0] w;
        w = {x, x} << n;
        return w[2*RC6_WORD_W-1:RC6_WORD_W];
    endfunction

    function automatic logic [RC6_WORD_W-1:0] f_rotr(input logic [RC6_WORD_W-1:0] x,
                                                      input logic [RC6_ROT_W-1:0]  n);
        logic [2*RC6_WORD_W-1:0] w;
        w = {x, x} >> n;
        return w[RC6_WORD_W-1:0];
    endfunction

    // x * (2x + 1), low word only
    function automatic logic [RC6_WORD_W-1:0] f_quad_prod(input logic [RC6_WORD_W-1:0] x);
        logic [RC6_WORD_W-1:0] y;
        y = x * {x[RC6_WORD_W-2:0], 1'b1};
        return y;
    endfunction

endpackage

`default_nettype wire

FILE: hdl/rc6_ram.sv
// ----------------------------------------------------------------------------
// RC6 RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_ram
    import rc6_pkg::*;
#(
    parameter int WIDTH = RC6_WORD_W,
    parameter int DEPTH = RC6_MAX_KEY_WORDS,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/rc6_round_unit.sv
// ----------------------------------------------------------------------------
// RC6 round unit
// Block registers with the shared quadratic, rotate and key-add datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module rc6_round_unit
    import rc6_pkg::*;
(
    input  logic                  i_clk,
    input  t_ru_ctrl              i_ctrl,
    input  t_block                i_block,
    input  logic [RC6_WORD_W-1:0] i_key_even,
    input  logic [RC6_WORD_W-1:0] i_key_odd,
    output t_block                o_block
);

    t_block                r_blk, n_blk;
    logic [RC6_WORD_W-1:0] r_pt, n_pt;
    logic [RC6_WORD_W-1:0] r_pu, n_pu;
    logic [RC6_WORD_W-1:0] w_t, w_u;
    logic [RC6_WORD_W-1:0] w_a2, w_c2;

    assign w_t = f_rotl(r_pt, RC6_LGW);
    assign w_u = f_rotl(r_pu, RC6_LGW);

    always_comb begin
        n_blk = r_blk;
        n_pt  = r_pt;
        n_pu  = r_pu;
        w_a2  = '0;
        w_c2  = '0;
        if (i_ctrl.load) begin
            n_blk = i_block;
        end else if (i_ctrl.zero) begin
            n_blk = '0;
        end else if (i_ctrl.pre) begin
            if (i_ctrl.dec) begin
                n_blk.a = r_blk.a - i_key_even;
                n_blk.c = r_blk.c - i_key_odd;
            end else begin
                n_blk.b = r_blk.b + i_key_even;
                n_blk.d = r_blk.d + i_key_odd;
            end
        end else if (i_ctrl.mul) begin
            // decrypt works on the words that the word rotation will bring to b and d
            n_pt = f_quad_prod(i_ctrl.dec ? r_blk.a : r_blk.b);
            n_pu = f_quad_prod(i_ctrl.dec ? r_blk.c : r_blk.d);
        end else if (i_ctrl.mix) begin
            if (i_ctrl.dec) begin
                w_a2  = f_rotr(r_blk.d - i_key_even, w_u[RC6_ROT_W-1:0]) ^ w_t;
                w_c2  = f_rotr(r_blk.b - i_key_odd, w_t[RC6_ROT_W-1:0]) ^ w_u;
                n_blk = '{a: w_a2, b: r_blk.a, c: w_c2, d: r_blk.c};
            end else begin
                w_a2  = f_rotl(r_blk.a ^ w_t, w_u[RC6_ROT_W-1:0]) + i_key_even;
                w_c2  = f_rotl(r_blk.c ^ w_u, w_t[RC6_ROT_W-1:0]) + i_key_odd;
                n_blk = '{a: r_blk.b, b: w_c2, c: r_blk.d, d: w_a2};
            end
        end else if (i_ctrl.post) begin
            if (i_ctrl.dec) begin
                n_blk.b = r_blk.b - i_key_even;
                n_blk.d = r_blk.d - i_key_odd;
            end else begin
                n_blk.a = r_blk.a + i_key_even;
                n_blk.c = r_blk.c + i_key_odd;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_pt  <= n_pt;
        r_pu  <= n_pu;
    end

    assign o_block = r_blk;

endmodule

`default_nettype wire

FILE: hdl/rc6_block_cipher_top.sv
// ----------------------------------------------------------------------------
// RC6 block cipher top level
// RC6-32 key loading, key expansion and block encrypt/decrypt, one request
// at a time, with a registered result stage.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake                  Payload
// in       input      i_in_valid / o_in_stall    t_in_item
// out      output     o_out_valid / i_out_stall  t_out_item
//
// Block request: S_PRE adds the first round keys, then each round passes S_MUL
//   and S_MIX on the shared multiply then rotate/add unit, then S_POST and S_DONE.
// Key word: stored in S_IDLE, result through S_DONE. Final key word: S_INIT writes
//   the round keys, one round-key write per cycle, then the key mixing steps run,
//   each through S_XRD, S_XA and S_XB.
// Reset clears the key count and marks the round keys as zero; no clearing pass.
// The input stalls while a request is in flight; a result waits in the output
// register under i_out_stall while the next request is accepted.
`default_nettype none
`include "rc6_block_cipher_top_defines.svh"

module rc6_block_cipher_top
    import rc6_pkg::*;
#(
    parameter int ROUNDS        = RC6_ROUNDS,
    parameter int MAX_KEY_WORDS = RC6_MAX_KEY_WORDS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    localparam int NUM_RK = 2 * ROUNDS + 4;
    localparam int BANK_D = ROUNDS + 2;
    localparam int BA_W   = $clog2(BANK_D);
    localparam int RK_W   = $clog2(NUM_RK);
    localparam int KC_W   = $clog2(MAX_KEY_WORDS + 1);
    localparam int KA_W   = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;
    localparam int MAXV   = (MAX_KEY_WORDS > NUM_RK) ? MAX_KEY_WORDS : NUM_RK;
    localparam int ST_W   = $clog2(3 * MAXV + 1);

    typedef enum logic [9:0] {
        S_IDLE = 10'b00_0000_0001,
        S_INIT = 10'b00_0000_0010,
        S_XRD  = 10'b00_0000_0100,
        S_XA   = 10'b00_0000_1000,
        S_XB   = 10'b00_0001_0000,
        S_PRE  = 10'b00_0010_0000,
        S_MUL  = 10'b00_0100_0000,
        S_MIX  = 10'b00_1000_0000,
        S_POST = 10'b01_0000_0000,
        S_DONE = 10'b10_0000_0000
    } t_state;

    t_state                r_state, n_state;
    logic                  r_dec, n_dec;
    logic [BA_W-1:0]       r_rnd, n_rnd;
    logic [RK_W-1:0]       r_i, n_i;
    logic [KA_W-1:0]       r_j, n_j;
    logic [KC_W-1:0]       r_kc, n_kc;
    logic [KC_W-1:0]       r_kcnt, n_kcnt;
    logic [ST_W-1:0]       r_steps, n_steps;
    logic [RC6_WORD_W-1:0] r_a, n_a;
    logic [RC6_WORD_W-1:0] r_b, n_b;
    logic [RC6_WORD_W-1:0] r_iv, n_iv;
    logic [1:0]            r_status, n_status;
    logic                  r_rk_valid, n_rk_valid;
    logic                  r_out_valid, n_out_valid;
    t_out_item             r_out, n_out;

    t_ru_ctrl              w_ru_ctrl;
    t_block                w_in_blk;
    t_block                w_blk;

    logic                  w_full;
    logic [KC_W-1:0]       w_cnew;
    logic [ST_W-1:0]       w_cmax;
    logic [ST_W-1:0]       w_steps;

    logic [BA_W-1:0]       w_rk_raddr;
    logic [BA_W-1:0]       w_rk_waddr;
    logic [RC6_WORD_W-1:0] w_rk_wdata;
    logic                  w_we_even, w_we_odd;
    logic [RC6_WORD_W-1:0] w_rd_even, w_rd_odd;
    logic [RC6_WORD_W-1:0] w_key_even, w_key_odd;

    logic                  w_kwe;
    logic [KA_W-1:0]       w_kwaddr;
    logic [RC6_WORD_W-1:0] w_kwdata;
    logic [RC6_WORD_W-1:0] w_krd;

    logic [RC6_WORD_W-1:0] w_s_rd;
    logic [RC6_WORD_W-1:0] w_a_mix;
    logic [RC6_WORD_W-1:0] w_ab;
    logic [RC6_WORD_W-1:0] w_b_mix;
    logic                  w_last_rnd;
    logic                  w_mixing;
    logic                  w_in_round;

    // round keys live in two banks: even entries and odd entries
    rc6_ram #(
        .WIDTH (RC6_WORD_W),
        .DEPTH (BANK_D)
    ) u_rk_even (
        .i_clk   (i_clk),
        .i_we    (w_we_even),
        .i_waddr (w_rk_waddr),
        .i_wdata (w_rk_wdata),
        .i_raddr (w_rk_raddr),
        .o_rdata (w_rd_even)
    );

    rc6_ram #(
        .WIDTH (RC6_WORD_W),
        .DEPTH (BANK_D)
    ) u_rk_odd (
        .i_clk   (i_clk),
        .i_we    (w_we_odd),
        .i_waddr (w_rk_waddr),
        .i_wdata (w_rk_wdata),
        .i_raddr (w_rk_raddr),
        .o_rdata (w_rd_odd)
    );

    rc6_ram #(
        .WIDTH (RC6_WORD_W),
        .DEPTH (MAX_KEY_WORDS)
    ) u_key_store (
        .i_clk   (i_clk),
        .i_we    (w_kwe),
        .i_waddr (w_kwaddr),
        .i_wdata (w_kwdata),
        .i_raddr (r_j),
        .o_rdata (w_krd)
    );

    assign w_in_blk = '{a: i_in_data.word_a, b: i_in_data.word_b,
                        c: i_in_data.word_c, d: i_in_data.word_d};

    rc6_round_unit u_round (
        .i_clk      (i_clk),
        .i_ctrl     (w_ru_ctrl),
        .i_block    (w_in_blk),
        .i_key_even (w_key_even),
        .i_key_odd  (w_key_odd),
        .o_block    (w_blk)
    );

    // round keys read as zero until the first expansion
    assign w_key_even = r_rk_valid ? w_rd_even : '0;
    assign w_key_odd  = r_rk_valid ? w_rd_odd  : '0;

    assign w_full  = (r_kcnt == KC_W'(MAX_KEY_WORDS));
    assign w_cnew  = w_full ? KC_W'(MAX_KEY_WORDS) : r_kcnt + KC_W'(1);
    assign w_cmax  = (ST_W'(w_cnew) > ST_W'(NUM_RK)) ? ST_W'(w_cnew) : ST_W'(NUM_RK);
    assign w_steps = (w_cmax << 1) + w_cmax;

    // key schedule mixing step
    assign w_s_rd  = r_i[0] ? w_key_odd : w_key_even;
    assign w_a_mix = f_rotl(w_s_rd + r_a + r_b, RC6_KEY_ROT);
    assign w_ab    = r_a + r_b;
    assign w_b_mix = f_rotl(w_krd + w_ab, w_ab[RC6_ROT_W-1:0]);

    assign w_rk_waddr = BA_W'(r_i >> 1);
    assign w_rk_wdata = (r_state == S_INIT) ? r_iv : w_a_mix;
    assign w_we_even  = ((r_state == S_INIT) || (r_state == S_XA)) && !r_i[0];
    assign w_we_odd   = ((r_state == S_INIT) || (r_state == S_XA)) && r_i[0];

    assign w_last_rnd = r_dec ? (r_rnd == BA_W'(1)) : (r_rnd == BA_W'(ROUNDS));

    assign w_mixing   = (r_state == S_XRD) || (r_state == S_XA) || (r_state == S_XB);
    assign w_in_round = (r_state == S_MUL) || (r_state == S_MIX);

    // present the key pair that the next state consumes
    always_comb begin
        unique case (r_state) inside
            S_IDLE: begin
                w_rk_raddr = (i_in_data.mode == MODE_DEC) ? BA_W'(ROUNDS + 1) : '0;
            end
            S_MUL: begin
                w_rk_raddr = r_rnd;
            end
            S_MIX: begin
                w_rk_raddr = r_dec ? '0 : BA_W'(ROUNDS + 1);
            end
            S_XRD, S_XA: begin
                w_rk_raddr = BA_W'(r_i >> 1);
            end
            default: begin
                w_rk_raddr = '0;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_dec       = r_dec;
        n_rnd       = r_rnd;
        n_i         = r_i;
        n_j         = r_j;
        n_kc        = r_kc;
        n_kcnt      = r_kcnt;
        n_steps     = r_steps;
        n_a         = r_a;
        n_b         = r_b;
        n_iv        = r_iv;
        n_status    = r_status;
        n_rk_valid  = r_rk_valid;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_ru_ctrl     = '0;
        w_ru_ctrl.dec = r_dec;
        w_kwe       = 1'b0;
        w_kwaddr    = r_j;
        w_kwdata    = w_b_mix;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_in_data.mode) inside
                        MODE_KEY: begin
                            w_ru_ctrl.zero = 1'b1;
                            if (!w_full) begin
                                w_kwe    = 1'b1;
                                w_kwaddr = r_kcnt[KA_W-1:0];
                                w_kwdata = i_in_data.key_word;
                                n_kcnt   = r_kcnt + KC_W'(1);
                                n_status = ST_STORED;
                            end else begin
                                n_status = ST_DROPPED;
                            end
                            if (i_in_data.key_final) begin
                                n_kc       = w_cnew;
                                n_steps    = w_steps;
                                n_kcnt     = '0;
                                n_i        = '0;
                                n_iv       = RC6_P32;
                                n_rk_valid = 1'b1;
                                n_state    = S_INIT;
                                if (!w_full) begin
                                    n_status = ST_EXPANDED;
                                end
                            end else begin
                                n_state = S_DONE;
                            end
                        end
                        MODE_ENC, MODE_DEC: begin
                            w_ru_ctrl.load = 1'b1;
                            n_dec    = (i_in_data.mode == MODE_DEC);
                            n_rnd    = (i_in_data.mode == MODE_DEC) ? BA_W'(ROUNDS) : BA_W'(1);
                            n_status = ST_BLOCK;
                            n_state  = S_PRE;
                        end
                        default: begin
                            w_ru_ctrl.zero = 1'b1;
                            n_status = ST_BLOCK;
                            n_state  = S_DONE;
                        end
                    endcase
                end
            end
            S_INIT: begin
                n_iv = r_iv + RC6_Q32;
                if (r_i == RK_W'(NUM_RK - 1)) begin
                    n_i     = '0;
                    n_j     = '0;
                    n_a     = '0;
                    n_b     = '0;
                    n_state = S_XRD;
                end else begin
                    n_i = r_i + RK_W'(1);
                end
            end
            S_XRD: begin
                n_state = S_XA;
            end
            S_XA: begin
                n_a     = w_a_mix;
                n_state = S_XB;
            end
            S_XB: begin
                w_kwe   = 1'b1;
                n_b     = w_b_mix;
                n_i     = (r_i == RK_W'(NUM_RK - 1)) ? '0 : r_i + RK_W'(1);
                n_j     = (KC_W'(r_j) == r_kc - KC_W'(1)) ? '0 : r_j + KA_W'(1);
                n_steps = r_steps - ST_W'(1);
                n_state = (r_steps == ST_W'(1)) ? S_DONE : S_XRD;
            end
            S_PRE: begin
                w_ru_ctrl.pre = 1'b1;
                n_state = S_MUL;
            end
            S_MUL: begin
                w_ru_ctrl.mul = 1'b1;
                n_state = S_MIX;
            end
            S_MIX: begin
                w_ru_ctrl.mix = 1'b1;
                if (w_last_rnd) begin
                    n_state = S_POST;
                end else begin
                    n_rnd   = r_dec ? r_rnd - BA_W'(1) : r_rnd + BA_W'(1);
                    n_state = S_MUL;
                end
            end
            S_POST: begin
                w_ru_ctrl.post = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                // hold until the output register frees up
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out.out_a  = w_blk.a;
                    n_out.out_b  = w_blk.b;
                    n_out.out_c  = w_blk.c;
                    n_out.out_d  = w_blk.d;
                    n_out.status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_kcnt      <= '0;
            r_rk_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kcnt      <= n_kcnt;
            r_rk_valid  <= n_rk_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dec    <= n_dec;
        r_rnd    <= n_rnd;
        r_i      <= n_i;
        r_j      <= n_j;
        r_kc     <= n_kc;
        r_steps  <= n_steps;
        r_a      <= n_a;
        r_b      <= n_b;
        r_iv     <= n_iv;
        r_status <= n_status;
        r_out    <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `RC6_ASSERT_RST(a_reset_idle, !i_rst_n |=> r_state == S_IDLE && !r_out_valid, "reset not idle")
    `RC6_ASSERT(a_kcnt_bound, r_kcnt <= KC_W'(MAX_KEY_WORDS), "key count beyond capacity")
    `RC6_ASSERT(a_j_bound, w_mixing |-> KC_W'(r_j) < r_kc, "key index beyond stored words")
    `RC6_ASSERT(a_rnd_bound, w_in_round |-> r_rnd != '0 && r_rnd <= BA_W'(ROUNDS), "bad round index")
    `RC6_ASSERT(a_out_from_done, $rose(r_out_valid) |-> $past(r_state == S_DONE), "stray result")

endmodule

`default_nettype wire
